// ----- src/camera_block_frame_parser_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the camera block frame parser
// Shared implication forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CAMERA_BLOCK_FRAME_PARSER_MACROS_SVH
`define CAMERA_BLOCK_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, muted during reset
`define CBFP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: ante -> cons");

// Next-cycle implication, muted during reset
`define CBFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: ante => cons");

`endif

// ----- src/cbfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cbfp_pkg
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbfp_pkg;

   localparam int unsigned MAX_BLOCKS_LIMIT = 128;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_BLOCKS   = 2'd0;
   localparam logic [1:0] CSR_SYNC_WORD    = 2'd1;
   localparam logic [1:0] CSR_SYNC_WORD_CC = 2'd2;

   // Configuration reset values
   localparam logic [7:0]  MAX_BLOCKS_RST   = 8'd128;
   localparam logic [15:0] SYNC_WORD_RST    = 16'hAA55;
   localparam logic [15:0] SYNC_WORD_CC_RST = 16'hAA56;

   localparam int unsigned TDATA_W = 104;
   localparam int unsigned TUSER_W = 3;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_CSUM,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      KIND_GOOD,
      KIND_CSUM_ERR,
      KIND_FRAME_END
   } kind_type;

   typedef struct packed {
      logic [7:0]  max_blocks;
      logic [15:0] sync_word;
      logic [15:0] sync_word_cc;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  block_count;
      logic [15:0] angle;
      logic [15:0] obj_height;
      logic [15:0] obj_width;
      logic [15:0] pos_y;
      logic [15:0] pos_x;
      logic [15:0] signature;
      logic        color_code;
      kind_type    kind;
   } result_type;

endpackage

`default_nettype wire

// ----- src/camera_block_frame_parser.sv -----
// Flow: a byte is registered in the input register on acceptance and parsed once the
//   result buffer has room; its result, if any, is written into the result buffer and
//   offered on rsp_ from there.
// Throughput: one byte per cycle while the two-entry result buffer has room; the
//   parser state update on each registered byte sets that rate.
// Reset: synchronous, active high; clears parser state and the result buffer and
//   restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// camera_block_frame_parser
// Parses a camera link byte stream into checksummed object blocks and frame ends.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_block_frame_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // byte stream in
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // rx_byte
   // results out
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // signature, pos_x, pos_y, obj_width, obj_height, angle, block_count
   output logic [cbfp_pkg::TDATA_W-1:0]        rsp_tdata,
   output logic [cbfp_pkg::TUSER_W-1:0]        rsp_tuser,   // kind, color_code
   // configuration writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [15:0]                    csr_wdata
);
   import cbfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_accept;
   logic       fire;
   logic       res_valid;
   result_type res;
   result_type out_res;
   logic       fifo_full;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_BLOCKS:   cfg_in.max_blocks   = csr_wdata[7:0];
            CSR_SYNC_WORD:    cfg_in.sync_word    = csr_wdata;
            CSR_SYNC_WORD_CC: cfg_in.sync_word_cc = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_blocks   <= MAX_BLOCKS_RST;
         cfg_ff.sync_word    <= SYNC_WORD_RST;
         cfg_ff.sync_word_cc <= SYNC_WORD_CC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: hold the byte until the parser takes it
   assign fire        = in_valid_ff && !fifo_full;
   assign req_tready  = !in_valid_ff || fire;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   cbfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg_ff),
      .fire_i      (fire),
      .byte_i      (in_byte_ff),
      .res_valid_o (res_valid),
      .res_o       (res)
   );

   cbfp_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_i      (res_valid),
      .push_data_i (res),
      .full_o      (fifo_full),
      .valid_o     (rsp_tvalid),
      .pop_i       (rsp_tready),
      .data_o      (out_res)
   );

   // Pack the result transaction
   assign rsp_tdata = {out_res.block_count, out_res.angle, out_res.obj_height,
                       out_res.obj_width, out_res.pos_y, out_res.pos_x,
                       out_res.signature};
   assign rsp_tuser = {out_res.color_code, out_res.kind};

endmodule

`default_nettype wire

// ----- src/cbfp_parser.sv -----
// ----------------------------------------------------------------------------
// cbfp_parser
// Word assembly, sync hunt, block checksum and frame end detection.
// ----------------------------------------------------------------------------
`default_nettype none

`include "camera_block_frame_parser_macros.svh"

module cbfp_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cbfp_pkg::cfg_type  cfg_i,
   input  wire logic               fire_i,
   input  wire logic [7:0]         byte_i,
   output logic                    res_valid_o,
   output cbfp_pkg::result_type    res_o
);
   import cbfp_pkg::*;

   logic        have_low_ff, have_low_in;
   logic [7:0]  low_hold_ff, low_hold_in;
   logic        drop_ff, drop_in;
   logic [15:0] prev_word_ff, prev_word_in;
   phase_type   phase_ff, phase_in;
   logic        btype_ff, btype_in;
   logic [2:0]  widx_ff, widx_in;
   logic [15:0] exp_sum_ff, exp_sum_in;
   logic [15:0] run_sum_ff, run_sum_in;
   logic [7:0]  blocks_ff, blocks_in;
   logic [15:0] fields_ff [6];
   logic        field_we;

   logic [15:0] word;
   logic [15:0] swapped;
   logic        word_fire;
   logic        hit_sw, hit_cc, hit_any, hit_type;
   logic        zero_restart, hunt_start;
   logic [7:0]  limit;
   logic        limit_zero, limit_hit;
   logic [2:0]  widx_next, nwords;
   logic        blk_done;
   logic [15:0] sum_next;
   logic        sum_ok;
   logic [15:0] data_words [6];

   // Decode the assembled word against the sync words
   assign word         = {byte_i, low_hold_ff};
   assign swapped      = {cfg_i.sync_word[7:0], cfg_i.sync_word[15:8]};
   assign word_fire    = fire_i && !drop_ff && have_low_ff;
   assign hit_sw       = (word == cfg_i.sync_word);
   assign hit_cc       = (word == cfg_i.sync_word_cc);
   assign hit_any      = hit_sw || hit_cc;
   assign hit_type     = !hit_sw;
   assign zero_restart = (word == 16'd0) && (prev_word_ff == 16'd0);
   assign hunt_start   = !zero_restart && hit_any && (prev_word_ff == cfg_i.sync_word);
   assign limit        = (cfg_i.max_blocks > 8'(MAX_BLOCKS_LIMIT)) ?
                         8'(MAX_BLOCKS_LIMIT) : cfg_i.max_blocks;
   assign limit_zero   = (limit == 8'd0);
   assign limit_hit    = (blocks_ff >= limit);
   assign widx_next    = widx_ff + 3'd1;
   assign nwords       = btype_ff ? 3'd6 : 3'd5;
   assign blk_done     = (widx_next == nwords);
   assign sum_next     = run_sum_ff + word;
   assign sum_ok       = (sum_next == exp_sum_ff);

   // Merge the current word into the stored data words
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         data_words[i] = (widx_ff == 3'(i)) ? word : fields_ff[i];
      end
   end

   // Next state
   always_comb begin
      have_low_in  = have_low_ff;
      low_hold_in  = low_hold_ff;
      drop_in      = drop_ff;
      prev_word_in = prev_word_ff;
      phase_in     = phase_ff;
      btype_in     = btype_ff;
      widx_in      = widx_ff;
      exp_sum_in   = exp_sum_ff;
      run_sum_in   = run_sum_ff;
      blocks_in    = blocks_ff;
      field_we     = 1'b0;
      if (fire_i) begin
         if (drop_ff) begin
            drop_in = 1'b0;
         end else if (!have_low_ff) begin
            low_hold_in = byte_i;
            have_low_in = 1'b1;
         end else begin
            have_low_in = 1'b0;
            unique case (phase_ff)
               PH_HUNT: begin
                  if (zero_restart) begin
                     prev_word_in = 16'hFFFF;
                  end else if (hunt_start) begin
                     btype_in  = hit_type;
                     blocks_in = 8'd0;
                     if (limit_zero) begin
                        prev_word_in = 16'hFFFF;
                     end else begin
                        phase_in = PH_CSUM;
                     end
                  end else begin
                     if (word == swapped) begin
                        drop_in = 1'b1;
                     end
                     prev_word_in = word;
                  end
               end
               PH_CSUM: begin
                  if (hit_any) begin
                     btype_in  = hit_type;
                     blocks_in = 8'd0;
                  end else if (word == 16'd0) begin
                     phase_in     = PH_HUNT;
                     prev_word_in = 16'hFFFF;
                  end else begin
                     exp_sum_in = word;
                     run_sum_in = 16'd0;
                     widx_in    = 3'd0;
                     phase_in   = PH_DATA;
                  end
               end
               PH_DATA: begin
                  field_we   = 1'b1;
                  run_sum_in = sum_next;
                  widx_in    = widx_next;
                  if (blk_done) begin
                     widx_in  = 3'd0;
                     phase_in = PH_TRAIL;
                     if (sum_ok) begin
                        blocks_in = blocks_ff + 8'd1;
                     end
                  end
               end
               PH_TRAIL: begin
                  if (hit_any) begin
                     btype_in = hit_type;
                     if (limit_hit) begin
                        phase_in     = PH_HUNT;
                        prev_word_in = 16'hFFFF;
                     end else begin
                        phase_in = PH_CSUM;
                     end
                  end else begin
                     phase_in     = PH_HUNT;
                     prev_word_in = 16'hFFFF;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   // Result for the current word
   always_comb begin
      res_valid_o = 1'b0;
      res_o       = '0;
      res_o.kind  = KIND_FRAME_END;
      if (word_fire) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (hunt_start && limit_zero) begin
                  res_valid_o      = 1'b1;
                  res_o.color_code = hit_type;
               end
            end
            PH_CSUM: begin
               if (hit_any || (word == 16'd0)) begin
                  res_valid_o       = 1'b1;
                  res_o.color_code  = btype_ff;
                  res_o.block_count = blocks_ff;
               end
            end
            PH_DATA: begin
               if (blk_done) begin
                  res_valid_o       = 1'b1;
                  res_o.kind        = sum_ok ? KIND_GOOD : KIND_CSUM_ERR;
                  res_o.color_code  = btype_ff;
                  res_o.signature   = data_words[0];
                  res_o.pos_x       = data_words[1];
                  res_o.pos_y       = data_words[2];
                  res_o.obj_width   = data_words[3];
                  res_o.obj_height  = data_words[4];
                  res_o.angle       = btype_ff ? data_words[5] : 16'd0;
                  res_o.block_count = sum_ok ? (blocks_ff + 8'd1) : blocks_ff;
               end
            end
            PH_TRAIL: begin
               if (!hit_any || limit_hit) begin
                  res_valid_o       = 1'b1;
                  res_o.color_code  = hit_any ? hit_type : btype_ff;
                  res_o.block_count = blocks_ff;
               end
            end
            default: begin
               res_valid_o = 1'b0;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         have_low_ff  <= 1'b0;
         low_hold_ff  <= 8'd0;
         drop_ff      <= 1'b0;
         prev_word_ff <= 16'hFFFF;
         phase_ff     <= PH_HUNT;
         btype_ff     <= 1'b0;
         widx_ff      <= 3'd0;
         exp_sum_ff   <= 16'd0;
         run_sum_ff   <= 16'd0;
         blocks_ff    <= 8'd0;
      end else begin
         have_low_ff  <= have_low_in;
         low_hold_ff  <= low_hold_in;
         drop_ff      <= drop_in;
         prev_word_ff <= prev_word_in;
         phase_ff     <= phase_in;
         btype_ff     <= btype_in;
         widx_ff      <= widx_in;
         exp_sum_ff   <= exp_sum_in;
         run_sum_ff   <= run_sum_in;
         blocks_ff    <= blocks_in;
      end
   end

   // Data words of the block in progress
   always_ff @(posedge clock) begin
      if (field_we) begin
         fields_ff[widx_ff] <= word;
      end
   end

   `CBFP_ASSERT_IMPL(a_drop_in_hunt, clock, reset, drop_ff, (!have_low_ff && phase_ff == PH_HUNT))
   `CBFP_ASSERT_IMPL(a_widx_range, clock, reset, (phase_ff == PH_DATA), (widx_ff < nwords))
   `CBFP_ASSERT_NEXT(a_good_counts, clock, reset, (res_valid_o && res_o.kind == KIND_GOOD), ((blocks_ff - $past(blocks_ff)) == 8'd1))
   `CBFP_ASSERT_NEXT(a_block_to_trail, clock, reset, (res_valid_o && res_o.kind != KIND_FRAME_END), (phase_ff == PH_TRAIL && widx_ff == 3'd0))

endmodule

`default_nettype wire

// ----- src/cbfp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// cbfp_out_fifo
// Two-entry result buffer between the parser and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "camera_block_frame_parser_macros.svh"

module cbfp_out_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_i,
   input  wire cbfp_pkg::result_type  push_data_i,
   output logic                       full_o,
   output logic                       valid_o,
   input  wire logic                  pop_i,
   output cbfp_pkg::result_type       data_o
);
   import cbfp_pkg::*;

   result_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign valid_o = (count_ff != 2'd0);
   assign full_o  = (count_ff == 2'd2);
   assign do_pop  = pop_i && valid_o;
   assign data_o  = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_i;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(push_i) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed result
   always_ff @(posedge clock) begin
      if (push_i) begin
         mem[wr_ptr_ff] <= push_data_i;
      end
   end

   `CBFP_ASSERT_IMPL(a_no_overflow, clock, reset, push_i, !full_o)
   `CBFP_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, (count_ff != 2'd3))
   `CBFP_ASSERT_IMPL(a_ptr_match, clock, reset, (count_ff == 2'd0 || count_ff == 2'd2), (wr_ptr_ff == rd_ptr_ff))

endmodule

`default_nettype wire
